@@ sv/pfa_pkg.sv @@
// Package for the partition fit allocator: sizes, result and mode codes,
// fit policy codes and the sequencer state type. No dependencies.
`default_nettype none
package pfa_pkg;
   localparam int NumParts   = 8;
   localparam int QueueDepth = 8;
   localparam int PartW      = $clog2(NumParts);
   localparam int QueueW     = $clog2(QueueDepth);
   localparam int CountW     = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      MODE_LOAD = 2'd0,
      MODE_REQ  = 2'd1,
      MODE_TICK = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_LOADED  = 3'd0,
      KIND_GRANTED = 3'd1,
      KIND_QUEUED  = 3'd2,
      KIND_REJECT  = 3'd3,
      KIND_FULL    = 3'd4,
      KIND_TICK    = 3'd5
   } kind_type;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;
   // The unused policy code behaves as first fit.
   localparam logic [1:0] POLICY_SPARE = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_SCAN,
      ST_EMIT,
      ST_TICKDONE
   } state_type;

   // Result of one search over the partition table.
   typedef struct packed {
      logic             found;
      logic [PartW-1:0] part;
      logic             fits_some;
   } pick_type;
endpackage
`default_nettype wire

@@ sv/pfa_picker.sv @@
// Shared partition search unit: picks a free partition under the fit policy.
// Depends on pfa_pkg.
`default_nettype none
module pfa_picker (
   input  wire logic [1:0]                                 policy,
   input  wire logic [15:0]                                size,
   input  wire logic [pfa_pkg::NumParts-1:0][15:0]         sizes,
   input  wire logic [pfa_pkg::NumParts-1:0]               busy,
   output pfa_pkg::pick_type                               pick
);
   always_comb begin
      logic found;
      logic [pfa_pkg::PartW-1:0] ch;
      logic fits;
      found = 1'b0;
      ch    = '0;
      fits  = 1'b0;
      for (int j = 0; j < pfa_pkg::NumParts; j++) begin
         if (sizes[j] >= size) fits = 1'b1;
         if (!busy[j] && sizes[j] >= size) begin
            if (!found) begin
               found = 1'b1;
               ch    = pfa_pkg::PartW'(j);
            end else if (policy == pfa_pkg::POLICY_BEST) begin
               if (sizes[j] < sizes[ch]) ch = pfa_pkg::PartW'(j);
            end else if (policy == pfa_pkg::POLICY_WORST) begin
               if (sizes[j] >= sizes[ch]) ch = pfa_pkg::PartW'(j);
            end
         end
      end
      pick.found     = found;
      pick.part      = ch;
      pick.fits_some = fits;
   end
endmodule
`default_nettype wire

@@ sv/partition_fit_allocator_top.sv @@
// Top level of the partition fit allocator: table, queue and sequencer.
// Depends on pfa_pkg and pfa_picker.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  mode, index, sizes, id, hold
//   rsp_      out        rsp_valid/rsp_stall  kind, id, part, time, last
//   csr_      in         csr_we               fit_policy
//
// A load or request passes the accept and emit states plus the output handshake. A
// tick takes an expiry step, then one search step per waiting request using the shared
// picker (a grant is loaded into the result register in the same cycle as its search),
// a closing step and a step for the tick-done result.
// Reset is synchronous and clears the table flags, counters and policy.
// A stalled result holds back the next grant or tick-done result.
// The block takes a new request only when idle and its result register is free.
`default_nettype none
module partition_fit_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [2:0]  req_part_index,
   input  wire logic [15:0] req_part_size,
   input  wire logic [7:0]  req_req_id,
   input  wire logic [15:0] req_req_size,
   input  wire logic [15:0] req_hold_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_out_id,
   output logic [2:0]       rsp_granted_part,
   output logic [31:0]      rsp_grant_time,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_fit_policy
);
   localparam int NP = pfa_pkg::NumParts;
   localparam int QD = pfa_pkg::QueueDepth;
   localparam int QueueWX = (pfa_pkg::QueueW < 1) ? 1 : pfa_pkg::QueueW;

   logic [1:0]                  policy_ff;
   logic [NP-1:0][15:0]         sizes_ff;
   logic [NP-1:0]               busy_ff;
   logic [NP-1:0][31:0]         release_ff;
   logic [31:0]                 now_ff;
   logic [QD-1:0][7:0]          qid_ff;
   logic [QD-1:0][15:0]         qsize_ff;
   logic [QD-1:0][15:0]         qhold_ff;
   logic [pfa_pkg::CountW-1:0]  count_ff;
   // Scan position and write-back position inside the queue during a tick.
   logic [pfa_pkg::CountW-1:0]  scan_ff, keep_ff, grants_ff;
   pfa_pkg::state_type          state_ff, state_in;

   // Latched request, feeding the shared picker outside of a tick.
   logic [1:0]  mode_ff;
   logic [2:0]  pidx_ff;
   logic [15:0] psize_ff, rsize_ff, hold_ff;
   logic [7:0]  id_ff;

   logic                rvalid_ff, rlast_ff;
   logic [2:0]          rkind_ff, rpart_ff;
   logic [7:0]          rid_ff;
   logic [31:0]         rtime_ff;

   logic [15:0]         pick_size;
   pfa_pkg::pick_type   pick;
   logic [QueueWX-1:0]  scan_idx;

   // Time since each partition's release point; a clear top bit means it is reached.
   logic [NP-1:0][31:0] age;
   logic [NP-1:0]       expired;

   logic out_free, accept, rsp_load;
   assign out_free  = !rvalid_ff || !rsp_stall;
   assign req_stall = (state_ff != pfa_pkg::ST_IDLE) || rvalid_ff;
   assign accept    = req_valid && !req_stall;
   assign scan_idx  = scan_ff[QueueWX-1:0];

   // A new result enters the output register this cycle.
   assign rsp_load = out_free &&
                     ((state_ff == pfa_pkg::ST_EMIT) || (state_ff == pfa_pkg::ST_TICKDONE) ||
                      ((state_ff == pfa_pkg::ST_SCAN) && (scan_ff < count_ff) &&
                       pick.found && (32'(grants_ff) < 8)));

   always_comb begin
      for (int j = 0; j < NP; j++) begin
         age[j]     = now_ff - release_ff[j];
         expired[j] = busy_ff[j] && !age[j][31];
      end
   end

   always_comb begin
      if (state_ff == pfa_pkg::ST_SCAN) pick_size = qsize_ff[scan_idx];
      else                               pick_size = rsize_ff;
   end

   pfa_picker u_picker (
      .policy (policy_ff),
      .size   (pick_size),
      .sizes  (sizes_ff),
      .busy   (busy_ff),
      .pick   (pick)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == pfa_pkg::MODE_TICK) state_in = pfa_pkg::ST_EXPIRE;
               else if (req_mode != pfa_pkg::MODE_NONE) state_in = pfa_pkg::ST_EMIT;
            end
         end
         pfa_pkg::ST_EMIT:     if (out_free) state_in = pfa_pkg::ST_IDLE;
         pfa_pkg::ST_EXPIRE:   state_in = pfa_pkg::ST_SCAN;
         pfa_pkg::ST_SCAN: begin
            if (scan_ff >= count_ff) state_in = pfa_pkg::ST_TICKDONE;
         end
         pfa_pkg::ST_TICKDONE: if (out_free) state_in = pfa_pkg::ST_IDLE;
         default:              state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pfa_pkg::ST_IDLE;
         policy_ff <= '0;
         sizes_ff  <= '0;
         busy_ff   <= '0;
         now_ff    <= '0;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         scan_ff   <= '0;
         keep_ff   <= '0;
         grants_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) policy_ff <= csr_fit_policy;
         if (rsp_load) rvalid_ff <= 1'b1;
         else if (!rsp_stall) rvalid_ff <= 1'b0;
         unique case (state_ff)
            pfa_pkg::ST_IDLE: begin
               if (accept) begin
                  mode_ff  <= req_mode;
                  pidx_ff  <= req_part_index;
                  psize_ff <= req_part_size;
                  id_ff    <= req_req_id;
                  rsize_ff <= req_req_size;
                  hold_ff  <= req_hold_time;
                  if (req_mode == pfa_pkg::MODE_TICK) now_ff <= now_ff + 32'd1;
               end
            end
            pfa_pkg::ST_EMIT: begin
               if (out_free) begin
                  rlast_ff  <= 1'b1;
                  rtime_ff  <= now_ff;
                  if (mode_ff == pfa_pkg::MODE_LOAD) begin
                     if (32'(pidx_ff) < NP) sizes_ff[pidx_ff[pfa_pkg::PartW-1:0]] <= psize_ff;
                     rkind_ff <= pfa_pkg::KIND_LOADED;
                     rid_ff   <= '0;
                     rpart_ff <= pidx_ff;
                  end else begin
                     rid_ff   <= id_ff;
                     rpart_ff <= '0;
                     if (!pick.fits_some) begin
                        rkind_ff <= pfa_pkg::KIND_REJECT;
                     end else if (pick.found) begin
                        rkind_ff <= pfa_pkg::KIND_GRANTED;
                        rpart_ff <= 3'(pick.part);
                        busy_ff[pick.part]    <= 1'b1;
                        release_ff[pick.part] <= now_ff + 32'(hold_ff);
                     end else if (32'(count_ff) >= QD) begin
                        rkind_ff <= pfa_pkg::KIND_FULL;
                     end else begin
                        rkind_ff <= pfa_pkg::KIND_QUEUED;
                        qid_ff[count_ff[QueueWX-1:0]]   <= id_ff;
                        qsize_ff[count_ff[QueueWX-1:0]] <= rsize_ff;
                        qhold_ff[count_ff[QueueWX-1:0]] <= hold_ff;
                        count_ff <= count_ff + 1'b1;
                     end
                  end
               end
            end
            pfa_pkg::ST_EXPIRE: begin
               busy_ff   <= busy_ff & ~expired;
               scan_ff   <= '0;
               keep_ff   <= '0;
               grants_ff <= '0;
            end
            pfa_pkg::ST_SCAN: begin
               if (scan_ff < count_ff) begin
                  if (pick.found && 32'(grants_ff) < 8) begin
                     // A grant needs the output register; wait otherwise.
                     if (out_free) begin
                        busy_ff[pick.part]    <= 1'b1;
                        release_ff[pick.part] <= now_ff + 32'(qhold_ff[scan_idx]);
                        rlast_ff  <= 1'b0;
                        rkind_ff  <= pfa_pkg::KIND_GRANTED;
                        rid_ff    <= qid_ff[scan_idx];
                        rpart_ff  <= 3'(pick.part);
                        rtime_ff  <= now_ff;
                        grants_ff <= grants_ff + 1'b1;
                        scan_ff   <= scan_ff + 1'b1;
                     end
                  end else begin
                     qid_ff[keep_ff[QueueWX-1:0]]   <= qid_ff[scan_idx];
                     qsize_ff[keep_ff[QueueWX-1:0]] <= qsize_ff[scan_idx];
                     qhold_ff[keep_ff[QueueWX-1:0]] <= qhold_ff[scan_idx];
                     keep_ff <= keep_ff + 1'b1;
                     scan_ff <= scan_ff + 1'b1;
                  end
               end else begin
                  count_ff <= keep_ff;
               end
            end
            pfa_pkg::ST_TICKDONE: begin
               if (out_free) begin
                  rlast_ff  <= 1'b1;
                  rkind_ff  <= pfa_pkg::KIND_TICK;
                  rid_ff    <= '0;
                  rpart_ff  <= '0;
                  rtime_ff  <= now_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rvalid_ff;
   assign rsp_kind         = rkind_ff;
   assign rsp_out_id       = rid_ff;
   assign rsp_granted_part = rpart_ff;
   assign rsp_grant_time   = rtime_ff;
   assign rsp_last         = rlast_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= pfa_pkg::CountW'(QD)) else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      keep_ff <= scan_ff) else $error("keep passed scan");
   assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == pfa_pkg::ST_IDLE) else $error("accept while busy");
   assert property (@(posedge clock) disable iff (reset)
      grants_ff <= pfa_pkg::CountW'(QD)) else $error("too many grants");
endmodule
`default_nettype wire
